/* src/hpd_pkg.sv */
// Shared types, constants and Hamming(12,8) helpers for the packet deframer.
// Used by hpd_core, hpd_outq and hamming_packet_deframer; no dependencies.
package hpd_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] IDLE_POS = 8'hFF;
    localparam logic [7:0] MIN_LEN  = 8'd10;
    localparam logic [7:0] LEN_HDR  = 8'd5;
    // x/3 == (x * 171) >> 9 for any 8-bit x
    localparam logic [7:0] RECIP3   = 8'd171;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_summary;
        logic [7:0]  payload_length;
        logic [7:0]  uncorrectable_count;
        logic [23:0] crc_received;
        logic        length_bad;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    typedef struct packed {
        logic       bad;
        logic [7:0] value;
    } word_t;

    // parity nibble contributed by each data bit
    function automatic logic [3:0] bit_parity(input logic [2:0] idx);
        logic [3:0] p;
        case (idx)
            3'd0:    p = 4'd3;
            3'd1:    p = 4'd5;
            3'd2:    p = 4'd6;
            3'd3:    p = 4'd7;
            3'd4:    p = 4'd9;
            3'd5:    p = 4'd10;
            3'd6:    p = 4'd11;
            3'd7:    p = 4'd12;
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    // data-bit flip mask for a syndrome; parity-bit syndromes give no flip
    function automatic logic [7:0] syn_fix(input logic [3:0] syn);
        logic [7:0] m;
        case (syn)
            4'd3:    m = 8'h01;
            4'd5:    m = 8'h02;
            4'd6:    m = 8'h04;
            4'd7:    m = 8'h08;
            4'd9:    m = 8'h10;
            4'd10:   m = 8'h20;
            4'd11:   m = 8'h40;
            4'd12:   m = 8'h80;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic word_t correct_word(input logic [7:0] v, input logic [3:0] par);
        logic [3:0] syn;
        word_t      w;
        syn = par;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                syn = syn ^ bit_parity(3'(i));
            end
        end
        w.bad   = (syn >= 4'd13);
        w.value = v ^ syn_fix(syn);
        return w;
    endfunction

    // residue mod 3 by folding base-4 digits (4 == 1 mod 3)
    function automatic logic [1:0] mod3(input logic [7:0] x);
        logic [3:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    endfunction

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] b);
        logic [8:0] s;
        s = 9'(a) + 9'(b);
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

/* src/hamming_packet_deframer.sv */
// Hamming(12,8) packet deframer: bytes in, corrected payload and summary out.
// Each byte is held in an input register while it is decoded; its results go to the
// result queue, and the second byte of a payload pair follows the first out of it.
// Throughput: one byte per cycle while results are taken; input stalls when the
// four-entry result queue has fewer than two free entries. Reset clears the control
// state, not stored data; the first byte after reset is taken as byte 0 of a packet.
module hamming_packet_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  hpd_pkg::in_item_t  byte_item,
    output logic               res_valid,
    input  logic               res_stall,
    output hpd_pkg::out_item_t res_item
);

    logic               room;
    hpd_pkg::push_t     push;
    hpd_pkg::out_item_t res0;
    hpd_pkg::out_item_t res1;

    hpd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .room       (room),
        .push       (push),
        .res0       (res0),
        .res1       (res1)
    );

    hpd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

/* src/hpd_core.sv */
// Input register and packet decode state: Hamming correction, length check,
// payload pairs and summary. Depends on hpd_pkg.
module hpd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  hpd_pkg::in_item_t byte_item,
    input  logic              room,
    output hpd_pkg::push_t    push,
    output hpd_pkg::out_item_t res0,
    output hpd_pkg::out_item_t res1
);

    logic               in_vld_reg, in_vld_next;
    hpd_pkg::in_item_t  in_item_reg;
    logic [7:0]         pos_reg, pos_next;
    logic [1:0]         phase_reg, phase_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         held_first_reg, held_first_next;
    logic [7:0]         held_second_reg, held_second_next;
    logic [7:0]         tally_reg, tally_next;
    logic [15:0]        crc_lo_reg, crc_lo_next;

    logic               advance;
    logic               start;
    logic [7:0]         b;
    logic [7:0]         p;
    logic [1:0]         ph;
    logic [7:0]         len;
    logic [7:0]         tally;
    logic [15:0]        crc_lo;
    hpd_pkg::word_t     w1, w2;
    logic [7:0]         tally_one, tally_pair;
    logic [7:0]         lm5, lm4, lm3, lm2;
    logic               len_bad;
    logic [7:0]         diff;
    logic [15:0]        prod;
    logic [7:0]         plen;

    assign advance    = in_vld_reg && room;
    assign byte_stall = in_vld_reg && !room;
    assign in_vld_next = byte_valid;

    assign start  = in_item_reg.packet_start;
    assign b      = in_item_reg.rx_byte;
    assign p      = start ? 8'd0  : pos_reg;
    assign ph     = start ? 2'd0  : phase_reg;
    assign len    = start ? 8'd0  : len_reg;
    assign tally  = start ? 8'd0  : tally_reg;
    assign crc_lo = start ? 16'd0 : crc_lo_reg;

    assign w1 = hpd_pkg::correct_word(held_first_reg, b[3:0]);
    assign w2 = hpd_pkg::correct_word(held_second_reg, b[7:4]);
    assign tally_one  = hpd_pkg::sat_add(tally, {1'b0, w1.bad});
    assign tally_pair = hpd_pkg::sat_add(tally, 2'(w1.bad) + 2'(w2.bad));

    assign lm5 = len - hpd_pkg::LEN_HDR;
    assign lm4 = len - 8'd4;
    assign lm3 = len - 8'd3;
    assign lm2 = len - 8'd2;

    assign len_bad = (w2.value < hpd_pkg::MIN_LEN)
                  || (hpd_pkg::mod3(w2.value - hpd_pkg::LEN_HDR) != 2'd0);

    // payload length = 2*((L-5)/3) - 1
    assign diff = lm5;
    assign prod = 16'(diff) * 16'(hpd_pkg::RECIP3);
    assign plen = {prod[15:9], 1'b0} - 8'd1;

    always_comb
    begin
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        len_next         = len_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        tally_next       = tally_reg;
        crc_lo_next      = crc_lo_reg;
        push             = '0;
        res0             = '0;
        res1             = '0;

        if (advance)
        begin
            pos_next    = p;
            phase_next  = ph;
            len_next    = len;
            tally_next  = tally;
            crc_lo_next = crc_lo;

            if (p == hpd_pkg::IDLE_POS)
            begin
                // between packets: bytes dropped
            end
            else if (p == 8'd0)
            begin
                held_first_next = b;
                pos_next        = 8'd1;
                phase_next      = 2'd1;
            end
            else if (p == 8'd1)
            begin
                held_second_next = b;
                pos_next         = 8'd2;
                phase_next       = 2'd2;
            end
            else if (p == 8'd2)
            begin
                len_next   = w2.value;
                tally_next = tally_pair;
                push.first = 1'b1;
                if (len_bad)
                begin
                    res0.is_summary          = 1'b1;
                    res0.uncorrectable_count = tally_pair;
                    res0.length_bad          = 1'b1;
                    res0.last                = 1'b1;
                    pos_next                 = hpd_pkg::IDLE_POS;
                end
                else
                begin
                    push.second    = 1'b1;
                    res0.data_byte = w1.value;
                    res1.data_byte = w2.value;
                    pos_next       = 8'd3;
                    phase_next     = 2'd0;
                end
            end
            else
            begin
                pos_next   = p + 8'd1;
                phase_next = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
                if (p < lm5)
                begin
                    case (ph)
                        2'd0:    held_first_next  = b;
                        2'd1:    held_second_next = b;
                        default:
                        begin
                            tally_next     = tally_pair;
                            push.first     = 1'b1;
                            push.second    = 1'b1;
                            res0.data_byte = w1.value;
                            res1.data_byte = w2.value;
                        end
                    endcase
                end
                else if (p == lm5 || p == lm2)
                begin
                    held_first_next = b;
                end
                else if (p == lm4)
                begin
                    held_second_next = b;
                end
                else if (p == lm3)
                begin
                    tally_next  = tally_pair;
                    crc_lo_next = {w2.value, w1.value};
                end
                else
                begin
                    // parity of the top CRC byte closes the packet
                    tally_next               = tally_one;
                    push.first               = 1'b1;
                    res0.is_summary          = 1'b1;
                    res0.payload_length      = plen;
                    res0.uncorrectable_count = tally_one;
                    res0.crc_received        = {w1.value, crc_lo};
                    res0.last                = 1'b1;
                    pos_next                 = hpd_pkg::IDLE_POS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            pos_reg         <= '0;
            phase_reg       <= '0;
            len_reg         <= '0;
            held_first_reg  <= '0;
            held_second_reg <= '0;
            tally_reg       <= '0;
            crc_lo_reg      <= '0;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_vld_reg <= in_vld_next;
            end
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            len_reg         <= len_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            tally_reg       <= tally_next;
            crc_lo_reg      <= crc_lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_item_reg <= byte_item;
        end
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second result pushed without first");

    a_summary_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (push.first && res0.is_summary) |=> (pos_reg == hpd_pkg::IDLE_POS))
        else $error("block not idle after summary");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !start && pos_reg == hpd_pkg::IDLE_POS) |-> !push.first)
        else $error("result produced while idle");

endmodule

/* src/hpd_outq.sv */
// Result queue: up to two items written per cycle, one read per cycle unless res_stall holds.
// Depends on hpd_pkg.
module hpd_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  hpd_pkg::push_t     push,
    input  hpd_pkg::out_item_t res0,
    input  hpd_pkg::out_item_t res1,
    output logic               room,
    output logic               res_valid,
    input  logic               res_stall,
    output hpd_pkg::out_item_t res_item
);

    hpd_pkg::out_item_t            mem [hpd_pkg::Q_DEPTH];
    logic [hpd_pkg::Q_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hpd_pkg::Q_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hpd_pkg::Q_CW-1:0]      count_reg, count_next;
    logic                          pop;
    logic [hpd_pkg::Q_AW-1:0]      wr_ptr_plus1;

    assign res_valid    = (count_reg != '0);
    assign res_item     = mem[rd_ptr_reg];
    assign pop          = res_valid && !res_stall;
    // two free entries needed before an item is decoded
    assign room         = (count_reg <= hpd_pkg::Q_CW'(hpd_pkg::Q_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + hpd_pkg::Q_AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + hpd_pkg::Q_AW'(push.first) + hpd_pkg::Q_AW'(push.second);
        rd_ptr_next = rd_ptr_reg + hpd_pkg::Q_AW'(pop);
        count_next  = count_reg + hpd_pkg::Q_CW'(push.first) + hpd_pkg::Q_CW'(push.second)
                    - hpd_pkg::Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[wr_ptr_reg] <= res0;
        end
        if (push.second)
        begin
            mem[wr_ptr_plus1] <= res1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hpd_pkg::Q_CW'(hpd_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> room)
        else $error("push without two free entries");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!push.first && !push.second && !pop) |=> $stable(count_reg))
        else $error("queue count changed without push or pop");

endmodule
